// File: rtl/wsc_pkg.sv
`default_nettype none

package wsc_pkg;

    // wave ram geometry
    localparam int WAVE_BYTES   = 16;
    localparam int SAMPLE_COUNT = 2 * WAVE_BYTES;
    localparam int WAVE_IDX_W   = $clog2(WAVE_BYTES);
    localparam int PTR_W        = WAVE_IDX_W + 1;

    // item kinds
    typedef enum logic [1:0] {
        KIND_WRITE    = 2'd0,
        KIND_READ     = 2'd1,
        KIND_FREQ     = 2'd2,
        KIND_LENGTH   = 2'd3
    } t_kind;

    // bus map
    localparam logic [15:0] ADDR_DAC    = 16'hFF1A;
    localparam logic [15:0] ADDR_LENGTH = 16'hFF1B;
    localparam logic [15:0] ADDR_LEVEL  = 16'hFF1C;
    localparam logic [15:0] ADDR_FREQ_LO = 16'hFF1D;
    localparam logic [15:0] ADDR_FREQ_HI = 16'hFF1E;
    localparam logic [15:0] WAVE_BASE   = 16'hFF30;
    localparam logic [15:0] WAVE_END    = WAVE_BASE + 16'(WAVE_BYTES);

    localparam logic [7:0]  LEVEL_READ_MASK = 8'h9F;
    localparam logic [11:0] PERIOD_BASE     = 12'd2048;
    localparam logic [8:0]  LENGTH_FULL     = 9'd256;

endpackage

`default_nettype wire

// File: rtl/wsc_if.sv
`default_nettype none

// input item channel
interface wsc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, output kind, output address, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input address, input write_data,
                    output ready);
endinterface

// result channel
interface wsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [3:0] sample;
    logic       channel_on;

    modport source (output valid, output read_data, output sample, output channel_on,
                    input ready);
    modport sink   (input valid, input read_data, input sample, input channel_on,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/wavetable_sound_channel_unit.sv
// an accepted item passes through the stage 1 registers and then the output register
// throughput: one item per cycle unless o_result.ready stalls; the wave ram has
// one write and one read port, and a sample refresh reads it once on accept
// reset: synchronous active-low i_rst_n clears control state and the per-byte
// valid bits, so unwritten wave ram bytes read as zero with no clearing pass
`default_nettype none

module wavetable_sound_channel_unit (
    input  wire       i_clk,
    input  wire       i_rst_n,
    wsc_in_if.sink    i_item,
    wsc_out_if.source o_result
);

    // channel state
    logic                       r_dac_on;
    logic                       r_enabled;
    logic [1:0]                 r_level;
    logic [7:0]                 r_freq_lo;
    logic [2:0]                 r_freq_hi;
    logic                       r_len_stop;
    logic [8:0]                 r_len_count;
    logic [12:0]                r_timer;
    logic [wsc_pkg::PTR_W-1:0]  r_ptr;
    logic [3:0]                 r_sample;

    logic                       n_dac_on;
    logic                       n_enabled;
    logic [1:0]                 n_level;
    logic [7:0]                 n_freq_lo;
    logic [2:0]                 n_freq_hi;
    logic                       n_len_stop;
    logic [8:0]                 n_len_count;
    logic [12:0]                n_timer;
    logic [wsc_pkg::PTR_W-1:0]  n_ptr;
    logic [7:0]                 n_read_data;
    logic                       n_reload;

    // wave ram and per-byte valid bits
    logic [7:0]                     mem [wsc_pkg::WAVE_BYTES];
    logic [wsc_pkg::WAVE_BYTES-1:0] r_mem_ok;
    logic [7:0]                     r_mem_q;
    logic                           r_mem_q_ok;

    // stage 1 registers
    logic       r_s1_valid;
    logic       r_s1_reload;
    logic       r_s1_mute;
    logic [1:0] r_s1_level;
    logic       r_s1_low_nib;
    logic [7:0] r_s1_read_data;
    logic       r_s1_on;

    // output registers
    logic       r_out_valid;
    logic [7:0] r_out_read_data;
    logic [3:0] r_out_sample;
    logic       r_out_on;

    logic                           out_advance;
    logic                           s1_advance;
    logic                           accept;
    logic                           wave_hit;
    logic [15:0]                    wave_offset;
    logic [wsc_pkg::WAVE_IDX_W-1:0] wave_wr_idx;
    logic [wsc_pkg::WAVE_IDX_W-1:0] wave_rd_idx;
    logic [11:0]                    freq_new;
    logic [12:0]                    period_new;
    logic [7:0]                     byte_q;
    logic [3:0]                     nib;
    logic [3:0]                     n_sample;

    // handshake
    assign out_advance    = !r_out_valid || o_result.ready;
    assign s1_advance     = r_s1_valid && out_advance;
    assign i_item.ready   = !r_s1_valid || out_advance;
    assign accept         = i_item.valid && i_item.ready;

    // wave ram decode
    assign wave_hit    = (i_item.address >= wsc_pkg::WAVE_BASE)
                      && (i_item.address < wsc_pkg::WAVE_END);
    assign wave_offset = i_item.address - wsc_pkg::WAVE_BASE;
    assign wave_wr_idx = wave_offset[wsc_pkg::WAVE_IDX_W-1:0];
    assign wave_rd_idx = n_ptr[wsc_pkg::PTR_W-1:1];

    // period from the frequency after this item's write
    assign freq_new   = {1'b0, n_freq_hi, n_freq_lo};
    assign period_new = {wsc_pkg::PERIOD_BASE - freq_new, 1'b0};

    // next channel state for the incoming item
    always_comb begin
        n_dac_on    = r_dac_on;
        n_enabled   = r_enabled;
        n_level     = r_level;
        n_freq_lo   = r_freq_lo;
        n_freq_hi   = r_freq_hi;
        n_len_stop  = r_len_stop;
        n_len_count = r_len_count;
        n_timer     = r_timer;
        n_ptr       = r_ptr;
        n_read_data = 8'h00;
        n_reload    = 1'b0;
        unique case (wsc_pkg::t_kind'(i_item.kind))
            wsc_pkg::KIND_WRITE: begin
                priority if (i_item.address == wsc_pkg::ADDR_DAC) begin
                    n_dac_on = i_item.write_data[7];
                end else if (i_item.address == wsc_pkg::ADDR_LENGTH) begin
                    n_len_count = {1'b0, i_item.write_data};
                end else if (i_item.address == wsc_pkg::ADDR_LEVEL) begin
                    n_level = i_item.write_data[6:5];
                end else if (i_item.address == wsc_pkg::ADDR_FREQ_LO) begin
                    n_freq_lo = i_item.write_data;
                end else if (i_item.address == wsc_pkg::ADDR_FREQ_HI) begin
                    n_freq_hi  = i_item.write_data[2:0];
                    n_len_stop = i_item.write_data[6];
                    // trigger
                    if (i_item.write_data[7]) begin
                        n_enabled = 1'b1;
                        if (r_len_count == '0) begin
                            n_len_count = wsc_pkg::LENGTH_FULL;
                        end
                        n_timer = period_new;
                        n_ptr   = '0;
                    end
                end else begin
                    n_dac_on = r_dac_on;
                end
            end
            wsc_pkg::KIND_READ: begin
                priority if (i_item.address == wsc_pkg::ADDR_DAC) begin
                    n_read_data = {8{r_enabled}};
                end else if (i_item.address == wsc_pkg::ADDR_LEVEL) begin
                    n_read_data = wsc_pkg::LEVEL_READ_MASK | {1'b0, r_level, 5'b0};
                end else if (i_item.address == wsc_pkg::ADDR_FREQ_LO) begin
                    n_read_data = r_freq_lo;
                end else if (i_item.address == wsc_pkg::ADDR_FREQ_HI) begin
                    n_read_data = {1'b0, r_len_stop, 3'b000, r_freq_hi};
                end else begin
                    n_read_data = 8'h00;
                end
            end
            wsc_pkg::KIND_FREQ: begin
                if (r_timer > 13'd1) begin
                    n_timer = r_timer - 13'd1;
                end else begin
                    n_reload = 1'b1;
                    n_timer  = period_new;
                    n_ptr    = (r_ptr == wsc_pkg::PTR_W'(wsc_pkg::SAMPLE_COUNT - 1))
                             ? '0 : r_ptr + 1'b1;
                end
            end
            wsc_pkg::KIND_LENGTH: begin
                if (r_len_count != '0) begin
                    n_len_count = r_len_count - 9'd1;
                    if (r_len_count == 9'd1 && r_len_stop) begin
                        n_enabled = 1'b0;
                    end
                end
            end
            default: begin
                n_read_data = 8'h00;
            end
        endcase
    end

    // channel state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dac_on    <= 1'b0;
            r_enabled   <= 1'b0;
            r_level     <= '0;
            r_freq_lo   <= '0;
            r_freq_hi   <= '0;
            r_len_stop  <= 1'b0;
            r_len_count <= '0;
            r_timer     <= '0;
            r_ptr       <= '0;
        end else if (accept) begin
            r_dac_on    <= n_dac_on;
            r_enabled   <= n_enabled;
            r_level     <= n_level;
            r_freq_lo   <= n_freq_lo;
            r_freq_hi   <= n_freq_hi;
            r_len_stop  <= n_len_stop;
            r_len_count <= n_len_count;
            r_timer     <= n_timer;
            r_ptr       <= n_ptr;
        end
    end

    // wave ram write and registered read
    always_ff @(posedge i_clk) begin
        if (accept && i_item.kind == wsc_pkg::KIND_WRITE && wave_hit) begin
            mem[wave_wr_idx] <= i_item.write_data;
        end
        if (accept && n_reload) begin
            r_mem_q <= mem[wave_rd_idx];
        end
    end

    // byte valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_ok   <= '0;
            r_mem_q_ok <= 1'b0;
        end else begin
            if (accept && i_item.kind == wsc_pkg::KIND_WRITE && wave_hit) begin
                r_mem_ok[wave_wr_idx] <= 1'b1;
            end
            if (accept && n_reload) begin
                r_mem_q_ok <= r_mem_ok[wave_rd_idx];
            end
        end
    end

    // stage 1: item info waiting on the ram read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_reload    <= n_reload;
            r_s1_mute      <= !(n_enabled && n_dac_on) || (n_level == '0);
            r_s1_level     <= n_level;
            r_s1_low_nib   <= n_ptr[0];
            r_s1_read_data <= n_read_data;
            r_s1_on        <= n_enabled;
        end
    end

    // sample refresh from the read byte
    assign byte_q = r_mem_q & {8{r_mem_q_ok}};
    assign nib    = r_s1_low_nib ? byte_q[3:0] : byte_q[7:4];

    always_comb begin
        n_sample = r_sample;
        if (r_s1_reload) begin
            n_sample = r_s1_mute ? 4'd0 : (nib >> (r_s1_level - 2'd1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (s1_advance) begin
            r_sample <= n_sample;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_read_data <= r_s1_read_data;
            r_out_sample    <= n_sample;
            r_out_on        <= r_s1_on;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.read_data  = r_out_read_data;
    assign o_result.sample     = r_out_sample;
    assign o_result.channel_on = r_out_on;

endmodule

`default_nettype wire
